>>> hw/rtl/osc_message_parser_macros.svh
// ----------------------------------------------------------------------------
// osc_message_parser_macros
// Assertion macros for the OSC message parser.
// ----------------------------------------------------------------------------
`ifndef OSC_MESSAGE_PARSER_MACROS_SVH
`define OSC_MESSAGE_PARSER_MACROS_SVH

// Implication that holds on every clock edge outside reset.
`define OMP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("osc_message_parser: check failed");

// Condition that never holds outside reset.
`define OMP_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("osc_message_parser: forbidden condition");

`endif

>>> hw/rtl/omp_pkg.sv
// ----------------------------------------------------------------------------
// omp_pkg
// Shared types and constants of the OSC message parser.
// ----------------------------------------------------------------------------
package omp_pkg;

  localparam int unsigned MaxTagsDefault = 16;
  localparam int unsigned QueueDepth     = 4;

  localparam logic [2:0] KindAddrChar = 3'd0;
  localparam logic [2:0] KindNumArg   = 3'd1;
  localparam logic [2:0] KindStrChar  = 3'd2;
  localparam logic [2:0] KindStrEnd   = 3'd3;
  localparam logic [2:0] KindMsgEnd   = 3'd4;

  localparam logic [2:0] StatusOk       = 3'd0;
  localparam logic [2:0] StatusBadLen   = 3'd1;
  localparam logic [2:0] StatusEmpty    = 3'd2;
  localparam logic [2:0] StatusAborted  = 3'd3;
  localparam logic [2:0] StatusOverflow = 3'd4;

  localparam logic [1:0] TypeInt  = 2'd0;
  localparam logic [1:0] TypeFlt  = 2'd1;
  localparam logic [1:0] TypeStr  = 2'd2;
  localparam logic [1:0] TypeUnk  = 2'd3;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTilde = 8'h7E;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChI     = 8'h69;
  localparam logic [7:0] ChF     = 8'h66;
  localparam logic [7:0] ChS     = 8'h73;

  // one result of the parser
  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  arg_index;
    logic [1:0]  arg_type;
    logic [31:0] value;
    logic [2:0]  status;
    logic [4:0]  arg_count;
    logic        address_empty;
    logic        last_of_run;
  } omp_result_t;

  // classified byte handed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       eop;
    logic       printable;
    logic       is_nul;
    logic       is_comma;
    logic [1:0] tag_class;
  } omp_item_t;

  function automatic logic [1:0] class_of(input logic [7:0] t);
    logic [1:0] c;
    c = TypeUnk;
    if (t == ChI) c = TypeInt;
    else if (t == ChF) c = TypeFlt;
    else if (t == ChS) c = TypeStr;
    return c;
  endfunction

endpackage

>>> hw/rtl/omp_front.sv
// ----------------------------------------------------------------------------
// omp_front
// Accepts bytes, classifies them and pushes them into a short queue.
// ----------------------------------------------------------------------------
module omp_front
  import omp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_packet_i,
  input  logic       pop_i,
  output logic       q_valid_o,
  output omp_item_t  q_item_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  omp_item_t        mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]    cnt_q, cnt_d;
  logic             push;
  omp_item_t        item;

  assign in_stall_o = (cnt_q == (PtrW+1)'(QueueDepth));
  assign push       = in_valid_i && !in_stall_o;

  always_comb begin
    item.data      = data_byte_i;
    item.eop       = end_of_packet_i;
    item.printable = (data_byte_i >= ChSpace) && (data_byte_i <= ChTilde);
    item.is_nul    = (data_byte_i == 8'h00);
    item.is_comma  = (data_byte_i == ChComma);
    item.tag_class = class_of(data_byte_i);
  end

  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> hw/rtl/omp_back.sv
// ----------------------------------------------------------------------------
// omp_back
// Parser state machine; emits results through an output register.
// ----------------------------------------------------------------------------
module omp_back
  import omp_pkg::*;
#(
  parameter int unsigned MaxTags = MaxTagsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  omp_item_t   q_item_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output omp_result_t res_o
);

  localparam int unsigned TagW = $clog2(MaxTags + 1);
  localparam int unsigned IdxW = (MaxTags > 1) ? $clog2(MaxTags) : 1;

  typedef enum logic [6:0] {
    PhAddr    = 7'b0000001,
    PhAddrPad = 7'b0000010,
    PhTags    = 7'b0000100,
    PhTagPad  = 7'b0001000,
    PhArgs    = 7'b0010000,
    PhArgPad  = 7'b0100000,
    PhDone    = 7'b1000000
  } phase_e;

  typedef enum logic [1:0] {
    StRun   = 2'b01,
    StFlush = 2'b10
  } step_e;

  logic [1:0]  tag_mem_q [MaxTags];
  phase_e      ph_q, ph_d;
  step_e       st_q, st_d;
  logic [1:0]  off_q, off_d, len_q, len_d;
  logic [TagW-1:0] tcnt_q, tcnt_d, carg_q, carg_d;
  logic        ovf_q, ovf_d;
  logic [23:0] wbuf_q, wbuf_d;
  logic [1:0]  wb_q, wb_d;
  logic        aempty_q, aempty_d, first_q, first_d, hasch_q, hasch_d;
  logic        abort_q, abort_d;
  logic        tag_we;
  logic [1:0]  cur_cls;

  logic        ov_q;
  omp_result_t ores_q;
  logic        emit;
  omp_result_t r;
  logic        can_emit;

  assign can_emit    = !ov_q || !out_stall_i;
  assign out_valid_o = ov_q;
  assign res_o       = ores_q;

  always_comb begin
    if (carg_q < TagW'(MaxTags)) cur_cls = tag_mem_q[carg_q[IdxW-1:0]];
    else cur_cls = TypeUnk;
  end

  function automatic phase_e post_of(input phase_e pad, input logic [TagW-1:0] tc,
                                     input logic [TagW-1:0] ca);
    phase_e p;
    p = (ca < tc) ? PhArgs : PhDone;
    if (pad == PhAddrPad) p = PhTags;
    else if (pad == PhTagPad) p = (tc != '0) ? PhArgs : PhDone;
    return p;
  endfunction

  always_comb begin
    logic [7:0] b;
    logic       ends;
    phase_e     padp;
    b = q_item_i.data;
    ends = 1'b0;
    padp = PhAddrPad;
    ph_d = ph_q; st_d = st_q; off_d = off_q; len_d = len_q;
    tcnt_d = tcnt_q; carg_d = carg_q; ovf_d = ovf_q; wbuf_d = wbuf_q; wb_d = wb_q;
    aempty_d = aempty_q; first_d = first_q; hasch_d = hasch_q; abort_d = abort_q;
    tag_we = 1'b0; emit = 1'b0; r = '0; pop_o = 1'b0;

    unique case (st_q)
      StRun: begin
        if (q_valid_i && can_emit) begin
          pop_o = 1'b1;
          unique case (ph_q)
            PhAddr: begin
              if (q_item_i.is_nul) begin
                aempty_d = !hasch_q; ends = 1'b1; padp = PhAddrPad;
              end else if (q_item_i.printable) begin
                emit = 1'b1; r.kind = KindAddrChar; r.value = {24'd0, b};
                hasch_d = 1'b1;
              end else begin
                aempty_d = 1'b1; ends = 1'b1; padp = PhAddrPad;
              end
            end
            PhTags: begin
              if (q_item_i.is_nul) begin
                ends = 1'b1; padp = PhTagPad;
              end else if (q_item_i.printable) begin
                if (!(first_q && q_item_i.is_comma)) begin
                  if (tcnt_q < TagW'(MaxTags)) begin
                    tag_we = 1'b1; tcnt_d = tcnt_q + 1'b1;
                  end else ovf_d = 1'b1;
                end
              end else begin
                tcnt_d = '0; ovf_d = 1'b0; ends = 1'b1; padp = PhTagPad;
              end
              first_d = 1'b0;
            end
            PhArgs: begin
              if (cur_cls == TypeUnk) begin
                abort_d = 1'b1; ph_d = PhDone;
              end else if (cur_cls == TypeStr) begin
                if (q_item_i.is_nul) begin
                  if (hasch_q) begin
                    emit = 1'b1; r.kind = KindStrEnd; r.arg_index = carg_q[3:0];
                    r.arg_type = TypeStr;
                    carg_d = carg_q + 1'b1; ends = 1'b1; padp = PhArgPad;
                  end else begin
                    abort_d = 1'b1; ph_d = PhDone;
                  end
                end else if (q_item_i.printable) begin
                  emit = 1'b1; r.kind = KindStrChar; r.arg_index = carg_q[3:0];
                  r.arg_type = TypeStr; r.value = {24'd0, b}; hasch_d = 1'b1;
                end else begin
                  abort_d = 1'b1; ph_d = PhDone;
                end
              end else begin
                if (wb_q == 2'd3) begin
                  emit = 1'b1; r.kind = KindNumArg; r.arg_index = carg_q[3:0];
                  r.arg_type = cur_cls; r.value = {wbuf_q, b};
                  wbuf_d = '0; wb_d = '0; carg_d = carg_q + 1'b1;
                  ph_d = ((carg_q + 1'b1) < tcnt_q) ? PhArgs : PhDone;
                end else begin
                  wbuf_d = {wbuf_q[15:0], b}; wb_d = wb_q + 1'b1;
                end
              end
            end
            PhAddrPad, PhTagPad, PhArgPad: begin
              if (off_q == 2'd3) ph_d = post_of(ph_q, tcnt_q, carg_q);
            end
            default: ;
          endcase
          if (ends) begin
            hasch_d = 1'b0;
            ph_d = (off_q == 2'd3) ? post_of(padp, tcnt_d, carg_d) : padp;
          end
          off_d = off_q + 1'b1;
          len_d = len_q + 1'b1;
          if (q_item_i.eop) begin
            st_d = StFlush;
            // resolve the phase at end of packet up front, as the flush loop expects
            if (len_d != 2'd0) begin
              ph_d = PhDone;
            end else begin
              if (ph_d == PhAddr) aempty_d = 1'b1;
              if (ph_d == PhTags) begin
                tcnt_d = '0; ovf_d = 1'b0;
              end
              if (ph_d == PhAddr || ph_d == PhAddrPad || ph_d == PhTags) ph_d = PhDone;
              if (ph_d == PhTagPad || ph_d == PhArgPad) ph_d = post_of(ph_d, tcnt_d, carg_d);
            end
            if (emit) r.last_of_run = 1'b0;
          end else begin
            r.last_of_run = 1'b1;
          end
        end
      end
      StFlush: begin
        if (can_emit) begin
          emit = 1'b1;
          if (ph_q == PhArgs && cur_cls != TypeStr && cur_cls != TypeUnk) begin
            unique case (wb_q)
              2'd0: r.value = '0;
              2'd1: r.value = {wbuf_q[7:0], 24'd0};
              2'd2: r.value = {wbuf_q[15:0], 16'd0};
              default: r.value = {wbuf_q, 8'd0};
            endcase
            r.kind = KindNumArg; r.arg_index = carg_q[3:0]; r.arg_type = cur_cls;
            wbuf_d = '0; wb_d = '0; carg_d = carg_q + 1'b1;
            ph_d = ((carg_q + 1'b1) < tcnt_q) ? PhArgs : PhDone;
          end else if (ph_q == PhArgs) begin
            abort_d = 1'b1; ph_d = PhDone; emit = 1'b0;
          end else begin
            r.kind = KindMsgEnd; r.last_of_run = 1'b1; r.address_empty = aempty_q;
            if (len_q != 2'd0) begin
              r.status = StatusBadLen;
            end else if (ovf_q) begin
              r.status = StatusOverflow;
              r.arg_count = abort_q ? 5'd0 : 5'(tcnt_q);
            end else if (abort_q) begin
              r.status = StatusAborted;
            end else if (tcnt_q == '0 && aempty_q) begin
              r.status = StatusEmpty;
            end else begin
              r.status = StatusOk; r.arg_count = 5'(tcnt_q);
            end
            st_d = StRun; ph_d = PhAddr; off_d = '0; len_d = '0; tcnt_d = '0;
            carg_d = '0; ovf_d = 1'b0; wbuf_d = '0; wb_d = '0; aempty_d = 1'b1;
            first_d = 1'b1; hasch_d = 1'b0; abort_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) tag_mem_q[tcnt_q[IdxW-1:0]] <= q_item_i.tag_class;
    if (emit) ores_q <= r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PhAddr; st_q <= StRun; off_q <= '0; len_q <= '0;
      tcnt_q <= '0; carg_q <= '0; ovf_q <= 1'b0; wbuf_q <= '0; wb_q <= '0;
      aempty_q <= 1'b1; first_q <= 1'b1; hasch_q <= 1'b0; abort_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      ph_q <= ph_d; st_q <= st_d; off_q <= off_d; len_q <= len_d;
      tcnt_q <= tcnt_d; carg_q <= carg_d; ovf_q <= ovf_d; wbuf_q <= wbuf_d;
      wb_q <= wb_d; aempty_q <= aempty_d; first_q <= first_d; hasch_q <= hasch_d;
      abort_q <= abort_d;
      if (emit) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
    end
  end

endmodule

>>> hw/rtl/osc_message_parser.sv
// Path: a byte is stored in a queue slot, and its first result then in the output register;
// an output stall holds later bytes in the queue.
// Throughput: one byte per cycle while neither the queue is full nor the output stalled;
// at packet end the back end flushes pending numeric arguments, then the message end.
// Reset: rst_ni, asynchronous active low, clears queue pointers and all parse state;
// the tag store holds no reset value and is only read after being written.
// ----------------------------------------------------------------------------
// osc_message_parser
// Byte-serial OSC message parser: front classifier, queue, back-end parser.
// ----------------------------------------------------------------------------
`include "osc_message_parser_macros.svh"

module osc_message_parser
  import omp_pkg::*;
#(
  parameter int unsigned MaxTags = MaxTagsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_packet_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [3:0]  arg_index_o,
  output logic [1:0]  arg_type_o,
  output logic [31:0] value_o,
  output logic [2:0]  status_o,
  output logic [4:0]  arg_count_o,
  output logic        address_empty_o,
  output logic        last_of_run_o
);

  logic        q_valid, pop;
  omp_item_t   q_item;
  omp_result_t res;

  // front: classify each byte and queue it
  omp_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .data_byte_i, .end_of_packet_i,
    .pop_i(pop), .q_valid_o(q_valid), .q_item_o(q_item)
  );

  // back: phase machine and output register
  omp_back #(.MaxTags(MaxTags)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_item_i(q_item), .pop_o(pop),
    .out_valid_o, .out_stall_i, .res_o(res)
  );

  assign kind_o          = res.kind;
  assign arg_index_o     = res.arg_index;
  assign arg_type_o      = res.arg_type;
  assign value_o         = res.value;
  assign status_o        = res.status;
  assign arg_count_o     = res.arg_count;
  assign address_empty_o = res.address_empty;
  assign last_of_run_o   = res.last_of_run;

  // a stalled result must hold
  `OMP_ASSERT_IMPL(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i, ##1 $stable(value_o))
  // the queue is never popped empty
  `OMP_ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, pop && !q_valid)
  // message end always closes a run
  `OMP_ASSERT_IMPL(a_end_last, clk_i, rst_ni,
                   out_valid_o && kind_o == KindMsgEnd, last_of_run_o)

endmodule
